// ----- src/vdd_pkg.sv -----
package vdd_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned MASK_WIDTH = 4;
   localparam logic [MASK_WIDTH-1:0] MASK_RESET = 4'hF;

   localparam int unsigned MASK_POS = 0;
   localparam int unsigned MASK_NRM = 1;
   localparam int unsigned MASK_TEX = 2;
   localparam int unsigned MASK_TINT = 3;

   typedef enum logic [1:0] {
      ST_NEW   = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] tint_rough;
      logic [WORD_WIDTH-1:0] tex_v;
      logic [WORD_WIDTH-1:0] tex_u;
      logic [WORD_WIDTH-1:0] nrm_z;
      logic [WORD_WIDTH-1:0] nrm_y;
      logic [WORD_WIDTH-1:0] nrm_x;
      logic [WORD_WIDTH-1:0] pos_z;
      logic [WORD_WIDTH-1:0] pos_y;
      logic [WORD_WIDTH-1:0] pos_x;
   } vertex_type;

endpackage

// ----- src/vdd_cell.sv -----
module vdd_cell #(
   parameter int unsigned MAX_VERTICES = 256,
   parameter int unsigned SLOT = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  vdd_pkg::vertex_type                query,
   input  logic [vdd_pkg::MASK_WIDTH-1:0]     mask,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]  count,
   input  logic                               wr_en,
   input  logic [$clog2(MAX_VERTICES)-1:0]    wr_slot,
   input  logic                               hit_prev,
   input  logic [$clog2(MAX_VERTICES)-1:0]    idx_prev,
   output logic                               hit_next,
   output logic [$clog2(MAX_VERTICES)-1:0]    idx_next
);

   localparam int unsigned IW = $clog2(MAX_VERTICES);
   localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

   vdd_pkg::vertex_type key_ff;
   logic                hit_ff;
   logic [IW-1:0]       idx_ff;
   logic                pos_eq;
   logic                nrm_eq;
   logic                tex_eq;
   logic                tint_eq;
   logic                in_use;
   logic                match;

   assign pos_eq = (key_ff.pos_x == query.pos_x) && (key_ff.pos_y == query.pos_y)
                   && (key_ff.pos_z == query.pos_z);
   assign nrm_eq = (key_ff.nrm_x == query.nrm_x) && (key_ff.nrm_y == query.nrm_y)
                   && (key_ff.nrm_z == query.nrm_z);
   assign tex_eq = (key_ff.tex_u == query.tex_u) && (key_ff.tex_v == query.tex_v);
   assign tint_eq = (key_ff.tint_rough == query.tint_rough);
   assign in_use = (count > CW'(SLOT));
   assign match = in_use
                  && (!mask[vdd_pkg::MASK_POS] || pos_eq)
                  && (!mask[vdd_pkg::MASK_NRM] || nrm_eq)
                  && (!mask[vdd_pkg::MASK_TEX] || tex_eq)
                  && (!mask[vdd_pkg::MASK_TINT] || tint_eq);

   always_ff @(posedge clock) begin
      if (wr_en && (wr_slot == IW'(SLOT))) begin
         key_ff <= query;
      end
      idx_ff <= match ? IW'(SLOT) : idx_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= match || hit_prev;
      end
   end

   assign hit_next = hit_ff;
   assign idx_next = idx_ff;

endmodule

// ----- src/vertex_deduplicator_unit.sv -----
// Vertex deduplicator.
// Input transactions on req_* carry one vertex: nine raw 32-bit attribute words in
// req_tdata and the start-of-mesh flag in req_tuser. Each vertex yields exactly one
// response transaction on rsp_* with the assigned index, the running unique count
// and a status code (new, duplicate, store full, no attributes selected).
// The user must write the compare mask through csr_write_enable / csr_write_data
// only while idle; the block itself does not enforce this. Stored vertices sit in
// a row of MAX_VERTICES cells. After a vertex is taken, each cell compares it with
// its own entry and the hit result ripples one cell per cycle toward the end of the
// row, where the highest matching slot survives. After acceptance the unit stays in
// SCAN while the hit result ripples through the cell row, then moves to FINISH, which
// resolves and writes the result register once the output is free, and returns to
// IDLE to take the next vertex. With an empty mask the SCAN state is skipped.
// The response is held in an output register, so the next vertex is accepted while a
// finished response still waits; a second result waits until rsp_tready frees it.
// Reset empties the store, clears the response register and sets the mask to all
// attributes. Store contents themselves are not cleared; only the count matters.
module vertex_deduplicator_unit #(
   parameter int unsigned MAX_VERTICES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v, tint_rough
   input  logic [287:0]                   req_tdata,
   // start_of_mesh
   input  logic [0:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // new_index [7:0], unique_total [16:8], zero fill
   output logic [23:0]                    rsp_tdata,
   // status
   output logic [1:0]                     rsp_tuser,
   input  logic                           csr_write_enable,
   input  logic [vdd_pkg::MASK_WIDTH-1:0] csr_write_data
);

   localparam int unsigned IW = $clog2(MAX_VERTICES);
   localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      FINISH
   } state_type;

   state_type                      state_ff;
   logic [vdd_pkg::MASK_WIDTH-1:0] mask_ff;
   logic [CW-1:0]                  count_ff;
   logic [IW-1:0]                  scan_ff;
   vdd_pkg::vertex_type            query_ff;
   logic                           rsp_valid_ff;
   logic [7:0]                     rsp_index_ff;
   logic [8:0]                     rsp_total_ff;
   vdd_pkg::status_type            rsp_status_ff;

   logic                           hit_chain [MAX_VERTICES+1];
   logic [IW-1:0]                  idx_chain [MAX_VERTICES+1];
   logic                           accept;
   logic                           out_free;
   logic                           store_full;
   logic                           wr_en;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign store_full = (count_ff == CW'(MAX_VERTICES));
   assign wr_en = (state_ff == FINISH) && out_free && (mask_ff != '0)
                  && !hit_chain[MAX_VERTICES] && !store_full;

   assign hit_chain[0] = 1'b0;
   assign idx_chain[0] = '0;

   for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
      vdd_cell #(
         .MAX_VERTICES(MAX_VERTICES),
         .SLOT(g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .query   (query_ff),
         .mask    (mask_ff),
         .count   (count_ff),
         .wr_en   (wr_en),
         .wr_slot (count_ff[IW-1:0]),
         .hit_prev(hit_chain[g]),
         .idx_prev(idx_chain[g]),
         .hit_next(hit_chain[g+1]),
         .idx_next(idx_chain[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         query_ff <= vdd_pkg::vertex_type'(req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         mask_ff <= vdd_pkg::MASK_RESET;
         count_ff <= '0;
         scan_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_index_ff <= '0;
         rsp_total_ff <= '0;
         rsp_status_ff <= vdd_pkg::ST_NEW;
      end else begin
         if (csr_write_enable) begin
            mask_ff <= csr_write_data;
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  if (req_tuser[0]) begin
                     count_ff <= '0;
                  end
                  scan_ff <= '0;
                  state_ff <= (mask_ff == '0) ? FINISH : SCAN;
               end
            end
            SCAN: begin
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == IW'(MAX_VERTICES - 1)) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= IDLE;
                  if (mask_ff == '0) begin
                     rsp_status_ff <= vdd_pkg::ST_EMPTY;
                     rsp_index_ff <= '0;
                     rsp_total_ff <= 9'(count_ff);
                  end else if (hit_chain[MAX_VERTICES]) begin
                     rsp_status_ff <= vdd_pkg::ST_DUP;
                     rsp_index_ff <= 8'(idx_chain[MAX_VERTICES]);
                     rsp_total_ff <= 9'(count_ff);
                  end else if (store_full) begin
                     rsp_status_ff <= vdd_pkg::ST_FULL;
                     rsp_index_ff <= '0;
                     rsp_total_ff <= 9'(count_ff);
                  end else begin
                     rsp_status_ff <= vdd_pkg::ST_NEW;
                     rsp_index_ff <= 8'(count_ff);
                     rsp_total_ff <= 9'(count_ff + 1'b1);
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_total_ff, rsp_index_ff};
   assign rsp_tuser = rsp_status_ff;

endmodule
